### src/plie_pkg.sv
package plie_pkg;

	// List geometry
	localparam int CAP   = 64;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);

	// Fixed field widths of the stream items
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int CPY_W = 7;
	localparam int OP_W  = 3;
	localparam int ST_W  = 2;

	// Width that holds position, count and count + copies without overflow
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_REMOVE = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_READ   = 3'd4,
		OP_WRITE  = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Per-cell update controls, in priority order
	typedef struct packed {
		logic load;     // take the broadcast word
		logic take_lo;  // take the lower neighbor's word (shift up)
		logic take_hi;  // take the upper neighbor's word (shift down)
	} cell_ctl_t;

endpackage

### src/plie_cell.sv
module plie_cell (
	input  logic                   clk,
	input  plie_pkg::cell_ctl_t    ctl,
	input  logic [plie_pkg::VAL_W-1:0] value_in,
	input  logic [plie_pkg::VAL_W-1:0] lo,
	input  logic [plie_pkg::VAL_W-1:0] hi,
	output logic [plie_pkg::VAL_W-1:0] word
);
	import plie_pkg::*;

	logic [VAL_W-1:0] word_q;

	// One list entry: load, shift up from below, or shift down from above
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= value_in;
		end else if (ctl.take_lo) begin
			word_q <= lo;
		end else if (ctl.take_hi) begin
			word_q <= hi;
		end
	end

	assign word = word_q;

endmodule

### src/positional_list_insert_erase.sv
// Positional list of signed 32-bit words held in a row of register cells.
// Input channel s_*: one operation per transfer; s_tuser carries the op code
// (append, remove last, insert, erase, read, write, clear).
// Output channel m_*: exactly one result per operation, in order; m_tdata
// holds the word read and the entry count after the operation, m_tuser the
// status (ok, full, empty, position out of range).
// Every operation except an insert of one or more copies that passes its checks
// finishes in the cycle it is accepted; its result is registered and shows on
// m_* in the next cycle. Such an insert places one copy per cycle, the entries
// from its position upward shifting up by one in each, and its result follows
// the last copy. One operation is in flight at a time; a new one is taken no
// earlier than the edge at which the previous result is transferred (one per
// cycle with the receiver ready; an insert holds the input while it places copies).
// Reset empties the list (entry count zero); entry contents are not cleared.
// While the receiver holds m_tready low the result register stays full and
// s_tready stays low.
module positional_list_insert_erase (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // position[6:0], value[38:7], copies[45:39], zero fill
	input  logic [2:0]  s_tuser,   // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_value[31:0], count[38:32], zero fill
	output logic [1:0]  m_tuser    // status[1:0]
);
	import plie_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_INS  = 2'b10
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CPY_W-1:0]   rem_q;
	logic [CMP_W-1:0]   ins_pos_q;
	logic [VAL_W-1:0]   ins_val_q;

	logic               out_valid_q;
	logic [VAL_W-1:0]   out_rd_q;
	logic [CNT_W-1:0]   out_cnt_q;
	status_t            out_st_q;

	logic               accept;
	op_t                op;
	logic [POS_W-1:0]   pos_in;
	logic [VAL_W-1:0]   val_in;
	logic [CPY_W-1:0]   cpy_in;
	logic [CMP_W-1:0]   pos_c;
	logic [CMP_W-1:0]   cnt_c;
	logic [CMP_W-1:0]   sum_c;

	status_t            st_n;
	logic [CNT_W-1:0]   cnt_n;
	logic [VAL_W-1:0]   rd_n;
	logic               start_ins;
	logic               do_append;
	logic               do_write;
	logic               do_erase;
	logic               ins_step;
	logic               ins_last;

	logic [VAL_W-1:0]   bcast;
	logic [VAL_W-1:0]   words [CAP];
	cell_ctl_t          ctls  [CAP];

	// Field unpacking
	assign accept = s_tvalid && s_tready;
	assign op     = op_t'(s_tuser);
	assign pos_in = s_tdata[POS_W-1:0];
	assign val_in = s_tdata[POS_W+VAL_W-1:POS_W];
	assign cpy_in = s_tdata[POS_W+VAL_W+CPY_W-1:POS_W+VAL_W];
	assign pos_c  = CMP_W'(pos_in);
	assign cnt_c  = CMP_W'(count_q);
	assign sum_c  = cnt_c + CMP_W'(cpy_in);

	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign ins_step = (state_q == S_INS);
	assign ins_last = ins_step && (rem_q == CPY_W'(1));

	// Operation decode and bounds checks
	always_comb begin
		st_n      = ST_OK;
		cnt_n     = count_q;
		rd_n      = '0;
		start_ins = 1'b0;
		do_append = 1'b0;
		do_write  = 1'b0;
		do_erase  = 1'b0;
		case (op)
			OP_APPEND: begin
				if (cnt_c >= CMP_W'(CAP)) begin
					st_n = ST_FULL;
				end else begin
					do_append = 1'b1;
					cnt_n     = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (count_q == '0) begin
					st_n = ST_EMPTY;
				end else begin
					cnt_n = count_q - CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (pos_c > cnt_c) begin
					st_n = ST_RANGE;
				end else if (sum_c > CMP_W'(CAP)) begin
					st_n = ST_FULL;
				end else if (cpy_in != '0) begin
					start_ins = 1'b1;
				end
			end
			OP_ERASE: begin
				if (count_q == '0) begin
					st_n = ST_EMPTY;
				end else if (pos_c >= cnt_c) begin
					st_n = ST_RANGE;
				end else begin
					do_erase = 1'b1;
					cnt_n    = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (pos_c >= cnt_c) begin
					st_n = ST_RANGE;
				end else begin
					rd_n = words[pos_c[IDX_W-1:0]];
				end
			end
			OP_WRITE: begin
				if (pos_c >= cnt_c) begin
					st_n = ST_RANGE;
				end else begin
					do_write = 1'b1;
				end
			end
			OP_CLEAR: begin
				cnt_n = '0;
			end
			default: begin
			end
		endcase
	end

	assign bcast = ins_step ? ins_val_q : val_in;

	// Cell row and its per-cell controls
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [VAL_W-1:0] lo_w;
		logic [VAL_W-1:0] hi_w;

		if (i == 0) begin : g_bot
			assign lo_w = '0;
		end else begin : g_lo
			assign lo_w = words[i-1];
		end
		if (i == CAP - 1) begin : g_top
			assign hi_w = words[i];
		end else begin : g_hi
			assign hi_w = words[i+1];
		end

		always_comb begin
			ctls[i].load    = (ins_step && (ins_pos_q == CMP_W'(i)))
				|| (accept && do_append && (cnt_c == CMP_W'(i)))
				|| (accept && do_write && (pos_c == CMP_W'(i)));
			ctls[i].take_lo = ins_step && (CMP_W'(i) > ins_pos_q);
			ctls[i].take_hi = accept && do_erase && (CMP_W'(i) >= pos_c);
		end

		plie_cell u_cell (
			.clk      (clk),
			.ctl      (ctls[i]),
			.value_in (bcast),
			.lo       (lo_w),
			.hi       (hi_w),
			.word     (words[i])
		);
	end

	// Sequencer: count, insert loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (start_ins) begin
							state_q <= S_INS;
							rem_q   <= cpy_in;
						end else begin
							count_q <= cnt_n;
						end
					end
				end
				S_INS: begin
					count_q <= count_q + CNT_W'(1);
					rem_q   <= rem_q - CPY_W'(1);
					if (ins_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Insert operands
	always_ff @(posedge clk) begin
		if (accept && start_ins) begin
			ins_pos_q <= pos_c;
			ins_val_q <= val_in;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ins_last || (accept && !start_ins)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_last) begin
			out_rd_q  <= '0;
			out_cnt_q <= count_q + CNT_W'(1);
			out_st_q  <= ST_OK;
		end else if (accept && !start_ins) begin
			out_rd_q  <= rd_n;
			out_cnt_q <= cnt_n;
			out_st_q  <= st_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, POS_W'(out_cnt_q), out_rd_q};
	assign m_tuser  = out_st_q;

endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import plie_pkg::*;

	localparam int LONG_HOLD    = 400;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = CAP + 8;
	localparam int MAX_REPORTS  = 20;

	// One list operation as it travels on the input stream
	typedef struct {
		op_t               op;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  value;
		logic [CPY_W-1:0]  copies;
	} list_cmd_t;

	// One result: word read, entry count, status
	typedef struct packed {
		logic [VAL_W-1:0]  read_word;
		logic [POS_W-1:0]  count;
		status_t           status;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // position[6:0], value[38:7], copies[45:39], zero fill
	logic [2:0]  s_tuser = OP_NONE;   // op[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // read_value[31:0], count[38:32], zero fill
	logic [1:0]  m_tuser;        // status[1:0]

	list_cmd_t    pending_cmds[$];
	list_result_t expected_results[$];
	list_cmd_t    live_cmd;

	// Shadow copy of the list
	logic [VAL_W-1:0] list_words[CAP];
	int               list_count = 0;

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int          hold_req = 0;
	int          hold_ack = 0;
	int          hold_left = 0;
	int          error_count = 0;
	int          quiet_cycles = 0;

	positional_list_insert_erase uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// Apply one accepted operation to the shadow list and queue its result
	task automatic predict_list_op(input list_cmd_t c);
		list_result_t r;
		int pos;
		int n;
		int i;
		pos = c.position;
		n = c.copies;
		r.read_word = '0;
		r.status = ST_OK;
		case (c.op)
			OP_APPEND: begin
				if (list_count >= CAP) begin
					r.status = ST_FULL;
				end else begin
					list_words[list_count] = c.value;
					list_count++;
				end
			end
			OP_REMOVE: begin
				if (list_count == 0) r.status = ST_EMPTY;
				else list_count--;
			end
			OP_INSERT: begin
				if (pos > list_count) begin
					r.status = ST_RANGE;
				end else if (list_count + n > CAP) begin
					r.status = ST_FULL;
				end else if (n != 0) begin
					// open a gap of n entries, then fill it
					for (i = list_count; i > pos; i--)
						list_words[i - 1 + n] = list_words[i - 1];
					for (i = 0; i < n; i++)
						list_words[pos + i] = c.value;
					list_count += n;
				end
			end
			OP_ERASE: begin
				if (list_count == 0) begin
					r.status = ST_EMPTY;
				end else if (pos >= list_count) begin
					r.status = ST_RANGE;
				end else begin
					for (i = pos; i + 1 < list_count; i++)
						list_words[i] = list_words[i + 1];
					list_count--;
				end
			end
			OP_READ: begin
				if (pos >= list_count) r.status = ST_RANGE;
				else r.read_word = list_words[pos];
			end
			OP_WRITE: begin
				if (pos >= list_count) r.status = ST_RANGE;
				else list_words[pos] = c.value;
			end
			OP_CLEAR: list_count = 0;
			default: ;
		endcase
		r.count = POS_W'(list_count);
		expected_results.insert(expected_results.size(), r);
	endtask

	// Driver: offer queued operations, hold each until its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= OP_NONE;
		end else begin
			if (s_tvalid && s_tready)
				predict_list_op(live_cmd);
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0
						&& $urandom_range(0, 99) >= sender_idle_pct) begin
					live_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, live_cmd.copies, live_cmd.value, live_cmd.position};
					s_tuser  <= live_cmd.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer, drive ready with stalls and long holds
	always @(posedge clk or negedge arst_n) begin
		list_result_t seen;
		list_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = {m_tdata[31:0], m_tdata[38:32], status_t'(m_tuser)};
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: unexpected result word=%h count=%0d status=%0d",
							$realtime, seen.read_word, seen.count, seen.status);
				end else begin
					want = expected_results.pop_front();
					if (seen != want) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display({"%0t: mismatch expected word=%h count=%0d ",
								"status=%0d, got word=%h count=%0d status=%0d"},
								$realtime, want.read_word, want.count, want.status,
								seen.read_word, seen.count, seen.status);
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack  <= hold_req;
				hold_left <= LONG_HOLD;
				m_tready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	task automatic queue_cmd(input op_t op, input int pos, input logic [VAL_W-1:0] val,
			input int copies);
		list_cmd_t c;
		c.op = op;
		c.position = POS_W'(pos);
		c.value = val;
		c.copies = CPY_W'(copies);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// Random operation, steered by the current shadow count so the list
	// wanders between empty and full
	task automatic gen_list_cmd(output list_cmd_t c);
		int unsigned roll;
		int unsigned top;
		c.value = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: c.value = 32'h7fff_ffff;
				1: c.value = 32'h8000_0000;
				2: c.value = 32'h0000_0000;
				default: c.value = 32'hffff_ffff;
			endcase
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) c.op = OP_NONE;
		else if (roll < 4) c.op = OP_CLEAR;
		else if (roll < 40) c.op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
		else if ($urandom_range(0, CAP) >= list_count)
			c.op = ($urandom_range(0, 1) == 0) ? OP_APPEND : OP_INSERT;
		else
			c.op = ($urandom_range(0, 2) == 0) ? OP_REMOVE : OP_ERASE;
		// insert may name count itself, the others stop one short
		top = (c.op == OP_INSERT) ? list_count : ((list_count > 0) ? list_count - 1 : 0);
		roll = $urandom_range(0, 99);
		if (roll < 88) c.position = POS_W'($urandom_range(0, top));
		else if (roll < 94) c.position = POS_W'(top + 1);
		else c.position = POS_W'($urandom_range(0, 127));
		roll = $urandom_range(0, 99);
		if (roll < 65) c.copies = 7'd1;
		else if (roll < 85) c.copies = CPY_W'($urandom_range(2, 4));
		else if (roll < 95) c.copies = CPY_W'($urandom_range(5, CAP));
		else c.copies = CPY_W'($urandom_range(0, 127));
	endtask

	task automatic wait_list_idle();
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Random phase; drain_every > 0 pauses the sender until all results are back
	task automatic run_random(input int n_items, input int unsigned s_pct,
			input int unsigned r_pct, input int drain_every);
		list_cmd_t c;
		int k;
		sender_idle_pct = s_pct;
		receiver_stall_pct = r_pct;
		for (k = 0; k < n_items; k++) begin
			while (pending_cmds.size() >= 2)
				@(negedge clk);
			gen_list_cmd(c);
			pending_cmds.insert(pending_cmds.size(), c);
			if (drain_every > 0 && k % drain_every == drain_every - 1)
				wait_list_idle();
		end
		wait_list_idle();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty-list errors, zero copies, extremes, fill to capacity
		queue_cmd(OP_REMOVE, 0, 32'h0, 1);
		queue_cmd(OP_ERASE, 0, 32'h0, 1);
		queue_cmd(OP_READ, 0, 32'h0, 1);
		queue_cmd(OP_WRITE, 0, 32'h1234_5678, 1);
		queue_cmd(OP_INSERT, 1, 32'h1111_1111, 1);
		queue_cmd(OP_INSERT, 0, 32'h2222_2222, 0);
		queue_cmd(OP_APPEND, 0, 32'h7fff_ffff, 1);
		queue_cmd(OP_APPEND, 127, 32'h8000_0000, 127);
		queue_cmd(OP_INSERT, 1, 32'hffff_ffff, 3);
		queue_cmd(OP_READ, 0, 32'h0, 1);
		queue_cmd(OP_READ, 4, 32'h0, 1);
		queue_cmd(OP_READ, 5, 32'h0, 1);
		queue_cmd(OP_WRITE, 2, 32'h0000_0000, 1);
		queue_cmd(OP_ERASE, 0, 32'h0, 1);
		queue_cmd(OP_ERASE, 127, 32'h0, 1);
		queue_cmd(OP_NONE, 127, 32'hffff_ffff, 127);
		queue_cmd(OP_INSERT, 0, 32'h3333_3333, 127);
		queue_cmd(OP_INSERT, 4, 32'h5a5a_a5a5, CAP - 4);
		queue_cmd(OP_APPEND, 0, 32'h4444_4444, 1);
		queue_cmd(OP_INSERT, CAP, 32'h5555_5555, 1);
		queue_cmd(OP_INSERT, CAP + 1, 32'h6666_6666, 1);
		queue_cmd(OP_READ, CAP - 1, 32'h0, 1);
		queue_cmd(OP_WRITE, CAP - 1, 32'h8000_0000, 1);
		queue_cmd(OP_ERASE, CAP - 1, 32'h0, 1);
		queue_cmd(OP_CLEAR, 0, 32'h0, 1);
		wait_list_idle();

		// Long receiver hold while the sender keeps offering
		hold_req++;
		run_random(350, 0, 0, 0);
		run_random(300, 88, 0, 0);
		run_random(300, 0, 88, 0);
		run_random(400, 14, 14, 100);
		run_random(550, 0, 0, 0);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
